// File: src/dpsm_pkg.sv
// Shared types, constants and codes for the DNA pattern stream matcher.
// No dependencies; every other source file refers to this package by scope.
package dpsm_pkg;

  localparam int MAX_PATTERN  = 64;
  localparam int MAX_SEQUENCE = 1048576;

  localparam int CODE_W   = 2;
  localparam int WIN_W    = CODE_W * MAX_PATTERN;
  localparam int LEN_W    = 7;
  localparam int SHAMT_W  = $clog2(MAX_PATTERN);
  localparam int COUNT_W  = $clog2(MAX_SEQUENCE + 1);
  localparam int START_W  = 20;
  localparam int CHAR_W   = 8;
  localparam int REG_W    = 64;
  localparam int ADDR_W   = 5;

  // register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  localparam logic [LEN_W-1:0] PAT_LEN_RESET = 7'd1;

  // accepted characters
  localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  localparam logic [CODE_W-1:0] BASE_A = 2'd0;
  localparam logic [CODE_W-1:0] BASE_C = 2'd1;
  localparam logic [CODE_W-1:0] BASE_G = 2'd2;
  localparam logic [CODE_W-1:0] BASE_T = 2'd3;

  typedef enum logic [1:0] {
    ST_BASE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_SPACE = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef struct packed {
    logic              is_base;
    logic              is_space;
    logic [CODE_W-1:0] code;
  } class_t;

  typedef struct packed {
    logic [REG_W-1:0] pat_low;
    logic [REG_W-1:0] pat_high;
    logic [LEN_W-1:0] pat_len;
  } cfg_t;

endpackage

// File: src/dpsm_cfg_regs.sv
// APB-style configuration registers: pattern bases and pattern length.
// Depends on dpsm_pkg.
module dpsm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpsm_pkg::ADDR_W-1:0] paddr,
  input  logic [dpsm_pkg::REG_W-1:0]  pwdata,
  output logic [dpsm_pkg::REG_W-1:0]  prdata,
  output logic                        pready,
  output dpsm_pkg::cfg_t              cfg
);

  logic [dpsm_pkg::REG_W-1:0] pat_low_r;
  logic [dpsm_pkg::REG_W-1:0] pat_high_r;
  logic [dpsm_pkg::LEN_W-1:0] pat_len_r;
  logic [1:0]                 reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= dpsm_pkg::PAT_LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        dpsm_pkg::REG_PAT_LOW:  pat_low_r  <= pwdata;
        dpsm_pkg::REG_PAT_HIGH: pat_high_r <= pwdata;
        dpsm_pkg::REG_PAT_LEN:  pat_len_r  <= pwdata[dpsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dpsm_pkg::REG_PAT_LOW:  prdata = pat_low_r;
      dpsm_pkg::REG_PAT_HIGH: prdata = pat_high_r;
      dpsm_pkg::REG_PAT_LEN:
        prdata = {{(dpsm_pkg::REG_W-dpsm_pkg::LEN_W){1'b0}}, pat_len_r};
      default:                prdata = '0;
    endcase
  end

  assign cfg.pat_low  = pat_low_r;
  assign cfg.pat_high = pat_high_r;
  assign cfg.pat_len  = pat_len_r;

endmodule

// File: src/dpsm_classify.sv
// Byte classifier: maps a text byte to a 2-bit base code, whitespace or invalid.
// Depends on dpsm_pkg.
module dpsm_classify (
  input  logic [dpsm_pkg::CHAR_W-1:0] char_byte,
  output dpsm_pkg::class_t            cls
);

  always_comb begin
    cls.is_base  = 1'b1;
    cls.is_space = 1'b0;
    cls.code     = dpsm_pkg::BASE_A;
    case (char_byte)
      dpsm_pkg::CH_A_UP, dpsm_pkg::CH_A_LO: cls.code = dpsm_pkg::BASE_A;
      dpsm_pkg::CH_C_UP, dpsm_pkg::CH_C_LO: cls.code = dpsm_pkg::BASE_C;
      dpsm_pkg::CH_G_UP, dpsm_pkg::CH_G_LO: cls.code = dpsm_pkg::BASE_G;
      dpsm_pkg::CH_T_UP, dpsm_pkg::CH_T_LO: cls.code = dpsm_pkg::BASE_T;
      dpsm_pkg::CH_SPACE, dpsm_pkg::CH_NL: begin
        cls.is_base  = 1'b0;
        cls.is_space = 1'b1;
      end
      default: begin
        cls.is_base = 1'b0;
      end
    endcase
  end

endmodule

// File: src/dpsm_match_core.sv
// Base window, saturating base counter, error latch and parallel pattern compare.
// Depends on dpsm_pkg.
module dpsm_match_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  dpsm_pkg::class_t             cls,
  input  dpsm_pkg::cfg_t               cfg,
  output dpsm_pkg::status_t            res_status,
  output logic [dpsm_pkg::START_W-1:0] res_start,
  output logic [dpsm_pkg::COUNT_W-1:0] res_count
);

  localparam int WIN_W   = dpsm_pkg::WIN_W;
  localparam int CODE_W  = dpsm_pkg::CODE_W;
  localparam int COUNT_W = dpsm_pkg::COUNT_W;
  localparam int LEN_W   = dpsm_pkg::LEN_W;

  // window entry j (age j, 0 newest) sits at bits 2j+1..2j
  logic [WIN_W-1:0]   window_r, window_nxt;
  logic [COUNT_W-1:0] seen_r, seen_nxt;
  logic               err_r, err_nxt;

  logic [WIN_W-1:0]   win_shift;
  logic [COUNT_W-1:0] seen_inc;
  logic [WIN_W-1:0]   pat_all;
  logic [WIN_W-1:0]   pat_rev;
  logic [WIN_W-1:0]   pat_align;
  logic [WIN_W-1:0]   cmp_mask;
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   len_gap;
  logic [dpsm_pkg::SHAMT_W-1:0] shamt;
  logic               hit;
  logic [COUNT_W-1:0] start_full;

  assign win_shift = {window_r[WIN_W-CODE_W-1:0], cls.code};
  assign seen_inc  = (seen_r < COUNT_W'(dpsm_pkg::MAX_SEQUENCE)) ?
                     seen_r + COUNT_W'(1) : seen_r;

  assign pat_all = {cfg.pat_high, cfg.pat_low};

  // reversed pattern: slot k holds pattern base MAX_PATTERN-1-k
  always_comb begin
    for (int k = 0; k < dpsm_pkg::MAX_PATTERN; k++) begin
      pat_rev[CODE_W*k +: CODE_W] =
        pat_all[CODE_W*(dpsm_pkg::MAX_PATTERN-1-k) +: CODE_W];
    end
  end

  assign eff_len = (cfg.pat_len > LEN_W'(dpsm_pkg::MAX_PATTERN)) ?
                   LEN_W'(dpsm_pkg::MAX_PATTERN) : cfg.pat_len;
  assign len_gap = LEN_W'(dpsm_pkg::MAX_PATTERN) - eff_len;
  assign shamt   = len_gap[dpsm_pkg::SHAMT_W-1:0];

  // after the shift, window entry j lines up with pattern base len-1-j
  assign pat_align = pat_rev >> {shamt, 1'b0};
  assign cmp_mask  = {WIN_W{1'b1}} >> {shamt, 1'b0};

  assign hit = (eff_len != '0) &&
               (seen_inc >= {{(COUNT_W-LEN_W){1'b0}}, eff_len}) &&
               (((win_shift ^ pat_align) & cmp_mask) == '0);

  assign start_full = seen_inc - {{(COUNT_W-LEN_W){1'b0}}, eff_len};

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    res_status = dpsm_pkg::ST_ERROR;
    res_start  = '0;
    res_count  = seen_r;
    if (err_r) begin
      res_status = dpsm_pkg::ST_ERROR;
    end else if (cls.is_space) begin
      res_status = dpsm_pkg::ST_SPACE;
    end else if (!cls.is_base) begin
      err_nxt    = 1'b1;
      res_status = dpsm_pkg::ST_ERROR;
    end else begin
      window_nxt = win_shift;
      seen_nxt   = seen_inc;
      res_count  = seen_inc;
      if (hit) begin
        res_status = dpsm_pkg::ST_MATCH;
        // count is at most MAX_SEQUENCE and length at least one: fits START_W
        res_start  = start_full[dpsm_pkg::START_W-1:0];
      end else begin
        res_status = dpsm_pkg::ST_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
      err_r    <= 1'b0;
    end else if (fire) begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// File: src/dna_pattern_stream_matcher_top.sv
// DNA pattern stream matcher, top level: input register, match core, result register.
// Depends on dpsm_pkg, dpsm_cfg_regs, dpsm_classify and dpsm_match_core.
//
// Usage:
//  - Input channel (in_valid / in_ready / in_char_byte) carries one raw text byte
//    per transaction. A/C/G/T in either case are bases, space and newline are
//    skipped, any other byte latches an error until reset.
//  - Result channel (out_valid / out_ready) returns exactly one transaction per
//    input byte: out_status, out_match_start, out_base_count.
//  - APB-style port programs the pattern: byte 0x00 bases 0..31, 0x08 bases
//    32..63 (two bits per base, A=0 C=1 G=2 T=3), 0x10 pattern length.
//    pready is tied high; write only while no transaction is in flight.
//  - Path: an accepted byte sits in the input register, is classified and
//    matched from there, and its result is captured in the result register.
//  - Throughput: one byte per cycle sustained while out_ready stays high.
//    The whole window compare is a single masked XOR of 64 bases against the
//    length-aligned pattern, so the state update is combinational between stages.
//  - Stall: when out_ready is low the result register holds; the input register
//    still takes one more byte, then in_ready drops until the result drains.
//  - Reset (rst_n low, synchronous): both stages empty, window and count zero,
//    error clear, pattern registers zero, pattern length one.
module dna_pattern_stream_matcher_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dpsm_pkg::CHAR_W-1:0]  in_char_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [dpsm_pkg::START_W-1:0] out_match_start,
  output logic [dpsm_pkg::COUNT_W-1:0] out_base_count,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpsm_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpsm_pkg::REG_W-1:0]   pwdata,
  output logic [dpsm_pkg::REG_W-1:0]   prdata,
  output logic                         pready
);

  // input stage
  logic                        inq_valid_r, inq_valid_nxt;
  logic [dpsm_pkg::CHAR_W-1:0] inq_char_r;

  // result stage
  logic                         out_valid_r, out_valid_nxt;
  dpsm_pkg::status_t            out_status_r;
  logic [dpsm_pkg::START_W-1:0] out_start_r;
  logic [dpsm_pkg::COUNT_W-1:0] out_count_r;

  logic                         advance;
  dpsm_pkg::cfg_t               cfg;
  dpsm_pkg::class_t             cls;
  dpsm_pkg::status_t            res_status;
  logic [dpsm_pkg::START_W-1:0] res_start;
  logic [dpsm_pkg::COUNT_W-1:0] res_count;

  dpsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpsm_classify u_classify (
    .char_byte (inq_char_r),
    .cls       (cls)
  );

  dpsm_match_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .cls        (cls),
    .cfg        (cfg),
    .res_status (res_status),
    .res_start  (res_start),
    .res_count  (res_count)
  );

  // byte moves to the result stage when that stage is empty or draining
  assign advance  = inq_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~inq_valid_r | advance;

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_valid && in_ready) begin
      inq_valid_nxt = 1'b1;
    end else if (advance) begin
      inq_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_char_r <= in_char_byte;
    end
    if (advance) begin
      out_status_r <= res_status;
      out_start_r  <= res_start;
      out_count_r  <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_start = out_start_r;
  assign out_base_count  = out_count_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for dna_pattern_stream_matcher_top: a byte-stream scoreboard
// with its own scan predictor, random idling and APB pattern programming.
// Depends on dpsm_pkg and dna_pattern_stream_matcher_top.
module tb_top;

  localparam logic [dpsm_pkg::START_W-1:0] START_LIMIT = '1;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned QUEUE_HIGH_WATER = 512;

  typedef struct {
    dpsm_pkg::status_t            status;
    logic [dpsm_pkg::START_W-1:0] start;
    logic [dpsm_pkg::COUNT_W-1:0] count;
  } scan_result_t;

  // DUT connections; every input starts at a known value
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [dpsm_pkg::CHAR_W-1:0]  in_char_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_status;
  logic [dpsm_pkg::START_W-1:0] out_match_start;
  logic [dpsm_pkg::COUNT_W-1:0] out_base_count;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [dpsm_pkg::ADDR_W-1:0]  paddr = '0;
  logic [dpsm_pkg::REG_W-1:0]   pwdata = '0;
  logic [dpsm_pkg::REG_W-1:0]   prdata;
  logic                         pready;

  dna_pattern_stream_matcher_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_byte    (in_char_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_match_start (out_match_start),
    .out_base_count  (out_base_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scan predictor: private copy of the window, base count, error flag and
  // pattern registers. Window, count and error update once per accepted input.
  // ---------------------------------------------------------------------------
  logic [dpsm_pkg::WIN_W-1:0]   model_window   = '0;   // bits 1:0 hold the newest base
  logic [dpsm_pkg::COUNT_W-1:0] model_seen     = '0;
  logic                         model_err      = 1'b0;
  logic [dpsm_pkg::REG_W-1:0]   model_pat_low  = '0;
  logic [dpsm_pkg::REG_W-1:0]   model_pat_high = '0;
  logic [dpsm_pkg::LEN_W-1:0]   model_pat_len  = dpsm_pkg::PAT_LEN_RESET;

  scan_result_t                results_due[$];   // expected result transactions, oldest first
  logic [dpsm_pkg::CHAR_W-1:0] bytes_pending[$]; // text bytes waiting for the driver
  int unsigned                 fail_count = 0;
  bit                          calm_mode = 1'b0; // no random idling on either side while set
  int unsigned                 holdoff_asked = 0;
  int unsigned                 holdoff_served = 0;

  function automatic logic [dpsm_pkg::CODE_W-1:0] pattern_code(input int unsigned idx);
    if (idx < 32) return model_pat_low[2*idx +: 2];
    return model_pat_high[2*(idx-32) +: 2];
  endfunction

  // lengths above the window size act as a full window; zero never matches
  function automatic int unsigned active_len();
    if (model_pat_len > dpsm_pkg::MAX_PATTERN) return dpsm_pkg::MAX_PATTERN;
    return int'(model_pat_len);
  endfunction

  function automatic scan_result_t predict_scan(input logic [dpsm_pkg::CHAR_W-1:0] ch);
    scan_result_t                 res;
    logic [dpsm_pkg::CODE_W-1:0]  code;
    logic                         is_base;
    logic                         is_space;
    logic                         hit;
    int unsigned                  span;
    logic [dpsm_pkg::COUNT_W-1:0] first_idx;
    res.status = dpsm_pkg::ST_BASE;
    res.start  = '0;
    is_base    = 1'b1;
    is_space   = 1'b0;
    code       = dpsm_pkg::BASE_A;
    case (ch)
      dpsm_pkg::CH_A_UP, dpsm_pkg::CH_A_LO: code = dpsm_pkg::BASE_A;
      dpsm_pkg::CH_C_UP, dpsm_pkg::CH_C_LO: code = dpsm_pkg::BASE_C;
      dpsm_pkg::CH_G_UP, dpsm_pkg::CH_G_LO: code = dpsm_pkg::BASE_G;
      dpsm_pkg::CH_T_UP, dpsm_pkg::CH_T_LO: code = dpsm_pkg::BASE_T;
      dpsm_pkg::CH_SPACE, dpsm_pkg::CH_NL: begin
        is_base  = 1'b0;
        is_space = 1'b1;
      end
      default: is_base = 1'b0;
    endcase
    if (model_err) begin
      res.status = dpsm_pkg::ST_ERROR;
    end else if (is_space) begin
      res.status = dpsm_pkg::ST_SPACE;
    end else if (!is_base) begin
      model_err  = 1'b1;
      res.status = dpsm_pkg::ST_ERROR;
    end else begin
      model_window = {model_window[dpsm_pkg::WIN_W-dpsm_pkg::CODE_W-1:0], code};
      if (model_seen < dpsm_pkg::MAX_SEQUENCE) model_seen++;
      span = active_len();
      if (span > 0 && model_seen >= span) begin
        hit = 1'b1;
        // oldest base of the candidate lines up with pattern base 0
        for (int i = 0; i < span; i++)
          if (model_window[2*(span-1-i) +: 2] != pattern_code(i)) hit = 1'b0;
        if (hit) begin
          res.status = dpsm_pkg::ST_MATCH;
          first_idx  = model_seen - span[dpsm_pkg::COUNT_W-1:0];
          res.start  = (first_idx > START_LIMIT) ? START_LIMIT
                                                 : first_idx[dpsm_pkg::START_W-1:0];
        end
      end
    end
    res.count = model_seen;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents one byte per transaction, holds it until accepted, then
  // optionally idles. Changes inputs on the falling edge only.
  // ---------------------------------------------------------------------------
  logic        in_taken = 1'b0;   // in_valid && in_ready at the last rising edge
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (bytes_pending.size() > 0) begin
        in_valid     <= 1'b1;
        in_char_byte <= bytes_pending.pop_front();
        gap_left     <= idle_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure. A hold-off request parks out_ready low for a long
  // stretch so the pipeline fills and in_ready drops.
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (holdoff_served != holdoff_asked) begin
      holdoff_served <= holdoff_asked;
      hold_left      <= HOLDOFF_CYCLES;
      out_ready      <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, predict accepted input transactions and
  // check accepted result transactions against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_result_t due;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) results_due.push_back(predict_scan(in_char_byte));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          due = results_due.pop_front();
          if (out_status !== due.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, due.status));
          if (out_match_start !== due.start)
            report_mismatch($sformatf("match_start got %0d want %0d",
                                      out_match_start, due.start));
          if (out_base_count !== due.count)
            report_mismatch($sformatf("base_count got %0d want %0d",
                                      out_base_count, due.count));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [dpsm_pkg::CHAR_W-1:0] b);
    // keep the queue bounded
    while (bytes_pending.size() > QUEUE_HIGH_WATER) @(posedge clk);
    bytes_pending.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [dpsm_pkg::CODE_W-1:0] rand_code();
    int unsigned r;
    r = $urandom_range(0, 3);
    return r[dpsm_pkg::CODE_W-1:0];
  endfunction

  function automatic logic [dpsm_pkg::CHAR_W-1:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 255);
    return r[dpsm_pkg::CHAR_W-1:0];
  endfunction

  function automatic logic [dpsm_pkg::LEN_W-1:0] rand_len(input int unsigned lo,
                                                          input int unsigned hi);
    int unsigned r;
    r = $urandom_range(lo, hi);
    return r[dpsm_pkg::LEN_W-1:0];
  endfunction

  function automatic logic [dpsm_pkg::CHAR_W-1:0] base_char(
      input logic [dpsm_pkg::CODE_W-1:0] code);
    logic lower;
    lower = ($urandom_range(0, 1) != 0);
    case (code)
      dpsm_pkg::BASE_A: return lower ? dpsm_pkg::CH_A_LO : dpsm_pkg::CH_A_UP;
      dpsm_pkg::BASE_C: return lower ? dpsm_pkg::CH_C_LO : dpsm_pkg::CH_C_UP;
      dpsm_pkg::BASE_G: return lower ? dpsm_pkg::CH_G_LO : dpsm_pkg::CH_G_UP;
      default:          return lower ? dpsm_pkg::CH_T_LO : dpsm_pkg::CH_T_UP;
    endcase
  endfunction

  function automatic logic [dpsm_pkg::CHAR_W-1:0] space_char();
    return ($urandom_range(0, 1) != 0) ? dpsm_pkg::CH_SPACE : dpsm_pkg::CH_NL;
  endfunction

  // pattern bases 0..n-1 in stream order, now and then split by whitespace
  task automatic push_pattern_run(input int unsigned n, output int unsigned pushed);
    pushed = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_byte(space_char());
        pushed++;
      end
      push_byte(base_char(pattern_code(i)));
      pushed++;
    end
  endtask

  // Half the picks are whole pattern occurrences with random case; the rest broken
  // prefixes, random bases and whitespace.
  task automatic push_phase(input int unsigned n_items);
    int unsigned done;
    int unsigned span;
    int unsigned pushed;
    int unsigned r;
    done = 0;
    span = active_len();
    if (span == 0) span = $urandom_range(1, 8);
    while (done < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        push_pattern_run(span, pushed);
        done += pushed;
      end else if (r < 7) begin
        push_pattern_run($urandom_range(0, span - 1), pushed);
        push_byte(base_char(rand_code()));
        done += pushed + 1;
      end else if (r < 9) begin
        pushed = $urandom_range(1, 6);
        for (int i = 0; i < pushed; i++) push_byte(base_char(rand_code()));
        done += pushed;
      end else begin
        push_byte(space_char());
        done++;
      end
    end
  endtask

  // wait until the block holds nothing and no result is outstanding
  task automatic drain();
    while (bytes_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // APB write (setup then access), then a read back of the same register;
  // pready is tied high
  task automatic config_write(input logic [1:0] idx,
                              input logic [dpsm_pkg::REG_W-1:0] value);
    logic [dpsm_pkg::REG_W-1:0] expect_rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dpsm_pkg::REG_PAT_LOW: begin
        model_pat_low = value;
        expect_rd     = value;
      end
      dpsm_pkg::REG_PAT_HIGH: begin
        model_pat_high = value;
        expect_rd      = value;
      end
      default: begin
        model_pat_len = value[dpsm_pkg::LEN_W-1:0];
        expect_rd     = {{(dpsm_pkg::REG_W-dpsm_pkg::LEN_W){1'b0}},
                         value[dpsm_pkg::LEN_W-1:0]};
      end
    endcase
    @(negedge clk);
    penable <= 1'b1;
    #1;
    if (prdata !== expect_rd)
      report_mismatch($sformatf("register %0d read %0h want %0h", idx, prdata, expect_rd));
    if (pready !== 1'b1)
      report_mismatch("pready low");
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_pattern(input logic [dpsm_pkg::REG_W-1:0] lo,
                                 input logic [dpsm_pkg::REG_W-1:0] hi,
                                 input logic [dpsm_pkg::LEN_W-1:0] len);
    drain();
    config_write(dpsm_pkg::REG_PAT_LOW, lo);
    config_write(dpsm_pkg::REG_PAT_HIGH, hi);
    config_write(dpsm_pkg::REG_PAT_LEN,
                 {{(dpsm_pkg::REG_W-dpsm_pkg::LEN_W){1'b0}}, len});
  endtask

  function automatic logic [dpsm_pkg::REG_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [dpsm_pkg::REG_W-1:0] lo;
    logic [dpsm_pkg::REG_W-1:0] hi;
    logic [dpsm_pkg::LEN_W-1:0] len;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset pattern is a single A. Both letter cases, both whitespace
    // characters, and matches from the very first base.
    push_text("ACGTacgt \n");
    // zero length: nothing may match
    program_pattern('0, '0, 7'd0);
    push_text("AAaa");
    // length above the window size behaves as 64; too little history to match
    program_pattern('0, '0, 7'd127);
    push_text("AaAa");
    // GAT: bases 0..2 = G, A, T
    program_pattern({58'd0, dpsm_pkg::BASE_T, dpsm_pkg::BASE_A, dpsm_pkg::BASE_G},
                    '0, 7'd3);
    push_text("gaTG\nAT");

    // Random phases with varying pattern registers, extremes first
    for (int p = 0; p < 12; p++) begin
      lo = rand_word();
      hi = rand_word();
      case (p)
        0: begin
          lo  = '1;
          hi  = '0;
          len = 7'd64;
        end
        1: begin
          hi  = '1;
          len = 7'd64;
        end
        2: len = 7'd0;
        3: len = 7'd100;
        4: len = 7'd1;
        5: len = rand_len(2, 8);
        default: len = ($urandom_range(0, 3) == 0) ? rand_len(1, 64) : rand_len(1, 10);
      endcase
      program_pattern(lo, hi, len);
      calm_mode = (p % 4 == 3);
      if (p == 5) begin
        // sender streams flat out while the receiver sits on its ready
        calm_mode = 1'b1;
        holdoff_asked++;
      end
      push_phase(80);
    end

    calm_mode = 1'b0;
    program_pattern(rand_word(), rand_word(), 7'd64);
    push_phase(80);
    program_pattern(rand_word(), rand_word(), 7'd1);
    push_phase(40);

    // Error tail: a non-ASCII byte latches the error; whitespace, bases and
    // any later byte must all come back as errors.
    push_byte(base_char(dpsm_pkg::BASE_C));
    push_byte(dpsm_pkg::CH_A_UP | 8'h80);
    push_byte(dpsm_pkg::CH_SPACE);
    push_byte(dpsm_pkg::CH_NL);
    push_byte(dpsm_pkg::CH_G_UP);
    push_byte(8'h00);
    push_byte(8'hFF);
    for (int k = 0; k < 60; k++) push_byte(rand_byte());

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: dna_pattern_stream_matcher_top.f
src/dpsm_pkg.sv
src/dpsm_cfg_regs.sv
src/dpsm_classify.sv
src/dpsm_match_core.sv
src/dna_pattern_stream_matcher_top.sv
tb/tb_top.sv
